// ----- rtl/hmrs_pkg.sv -----
// hmrs_pkg: shared types and constants for the height map rectangle stack core.
// Used by height_map_rect_stack_core; no dependencies of its own.

package hmrs_pkg;

  // Fixed field widths of the ports
  localparam int CoordW = 6;
  localparam int BoxW   = 16;
  localparam int TopW   = 16;
  localparam int CfgIdxW = 1;
  // Width for comparing a coordinate against a grid bound or lane number
  localparam int CmpW   = 13;

  // Config register indexes
  localparam logic [CfgIdxW-1:0] CFG_X_LAST = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_Y_LAST = 1'b1;

  // Reset value of both limit registers
  localparam logic [CoordW-1:0] LAST_RST = 6'd63;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAX_RD,
    ST_DRAIN,
    ST_SUM,
    ST_WR_RD,
    ST_WR_LAST,
    ST_DONE
  } state_e;

  // Control decoded from the sequencer state
  typedef struct packed {
    logic in_ready;
    logic rd_max;    // read a row for the maximum pass
    logic rd_wr;     // read a row for the update pass
    logic x_inc;     // step to the next row
    logic sum_ld;    // capture the saturated sum
    logic out_ld;    // move the result to the output register
  } ctrl_t;

endpackage

// ----- rtl/height_map_rect_stack_core.sv -----
// height_map_rect_stack_core: contour height map with rectangle max-and-assign.
// Depends on hmrs_pkg (types, widths, config indexes).

// The grid is held as GRID_X rows, one row of GRID_Y heights per memory word.
// A word is accepted only while the core is idle. For a rectangle covering R
// rows after clipping to x_last/y_last and the grid, the core reads those R
// rows one per cycle through a registered max tree of log2(GRID_Y) levels,
// then reads and rewrites the same R rows one per cycle (read-modify-write on
// the single row memory). An empty or fully clipped rectangle skips both
// row passes. While a previous new_top still waits on the output, the core
// holds the next result in its done state. Each row has a valid bit cleared
// by reset, and a row never written reads as all zero, so there is no
// clearing pass after reset. The result register lets the next word be
// accepted while new_top waits.

module height_map_rect_stack_core #(
  parameter int GRID_X      = 64,
  parameter int GRID_Y      = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [hmrs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hmrs_pkg::CoordW-1:0]   cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hmrs_pkg::CoordW-1:0]   x_low_i,
  input  logic [hmrs_pkg::CoordW-1:0]   y_low_i,
  input  logic [hmrs_pkg::CoordW-1:0]   x_high_i,
  input  logic [hmrs_pkg::CoordW-1:0]   y_high_i,
  input  logic [hmrs_pkg::BoxW-1:0]     box_height_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hmrs_pkg::TopW-1:0]     new_top_o
);

  localparam int HB    = HEIGHT_BITS;
  localparam int XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int NP    = (GRID_Y < 2) ? 2 : (1 << $clog2(GRID_Y));
  localparam int LV    = $clog2(NP);
  localparam int RW    = GRID_Y * HB;
  localparam int SW    = ((HB > hmrs_pkg::BoxW) ? HB : hmrs_pkg::BoxW) + 1;
  localparam int CW    = hmrs_pkg::CmpW;
  localparam logic [CW-1:0] XMAX = CW'(GRID_X - 1);
  localparam logic [CW-1:0] YMAX = CW'(GRID_Y - 1);
  localparam logic [SW-1:0] HMAX = {{(SW - HB){1'b0}}, {HB{1'b1}}};

  hmrs_pkg::state_e state_q, state_d;
  hmrs_pkg::ctrl_t  ctrl;

  // limit registers
  logic [hmrs_pkg::CoordW-1:0] x_last_q, y_last_q;

  // latched rectangle
  logic [hmrs_pkg::CoordW-1:0] xl_q, yl_q, xh_q, yh_q, x_q;
  logic [hmrs_pkg::BoxW-1:0]   add_q;
  logic                        live_q;

  // row store
  logic [RW-1:0]      mem [GRID_X];
  logic [GRID_X-1:0]  row_vld_q;
  logic [XW-1:0]      raddr;
  logic [RW-1:0]      rd_q;
  logic               rvb_q;
  logic               rdmx_q, rdwr_q;
  logic [XW-1:0]      wa_q;
  logic [RW-1:0]      wdata;

  // max tree
  logic [HB-1:0]      leaf   [NP];
  logic [HB-1:0]      tree_q [NP-1];
  logic [LV-1:0]      pipe_q;
  logic [HB-1:0]      acc_q;

  // sum and result
  logic [SW-1:0]      sum_w;
  logic [HB-1:0]      sum_q;
  logic               out_v_q;
  logic [hmrs_pkg::TopW-1:0] top_q;

  // clipping of the incoming rectangle
  logic [hmrs_pkg::CoordW-1:0] xh_c, yh_c;
  logic                        live_c;
  logic                        accept;

  assign accept = in_valid_i & ctrl.in_ready;

  always_comb begin
    xh_c = (x_high_i > x_last_q) ? x_last_q : x_high_i;
    if (CW'(xh_c) > XMAX) begin
      xh_c = hmrs_pkg::CoordW'(XMAX);
    end
    yh_c = (y_high_i > y_last_q) ? y_last_q : y_high_i;
    if (CW'(yh_c) > YMAX) begin
      yh_c = hmrs_pkg::CoordW'(YMAX);
    end
    live_c = (x_low_i <= xh_c) && (y_low_i <= yh_c);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hmrs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = live_c ? hmrs_pkg::ST_MAX_RD : hmrs_pkg::ST_SUM;
        end
      end
      hmrs_pkg::ST_MAX_RD: begin
        if (x_q == xh_q) begin
          state_d = hmrs_pkg::ST_DRAIN;
        end
      end
      hmrs_pkg::ST_DRAIN: begin
        if (!rdmx_q && (pipe_q == '0)) begin
          state_d = hmrs_pkg::ST_SUM;
        end
      end
      hmrs_pkg::ST_SUM: begin
        state_d = live_q ? hmrs_pkg::ST_WR_RD : hmrs_pkg::ST_DONE;
      end
      hmrs_pkg::ST_WR_RD: begin
        if (x_q == xh_q) begin
          state_d = hmrs_pkg::ST_WR_LAST;
        end
      end
      hmrs_pkg::ST_WR_LAST: state_d = hmrs_pkg::ST_DONE;
      hmrs_pkg::ST_DONE: begin
        if (!out_v_q || out_ready_i) begin
          state_d = hmrs_pkg::ST_IDLE;
        end
      end
      default: state_d = hmrs_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      hmrs_pkg::ST_IDLE:    ctrl.in_ready = 1'b1;
      hmrs_pkg::ST_MAX_RD: begin
        ctrl.rd_max = 1'b1;
        ctrl.x_inc  = 1'b1;
      end
      hmrs_pkg::ST_DRAIN:   ctrl = '0;
      hmrs_pkg::ST_SUM:     ctrl.sum_ld = 1'b1;
      hmrs_pkg::ST_WR_RD: begin
        ctrl.rd_wr = 1'b1;
        ctrl.x_inc = 1'b1;
      end
      hmrs_pkg::ST_WR_LAST: ctrl = '0;
      hmrs_pkg::ST_DONE:    ctrl.out_ld = !out_v_q || out_ready_i;
      default:              ctrl = '0;
    endcase
  end

  assign in_ready_o = ctrl.in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hmrs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_last_q <= hmrs_pkg::LAST_RST;
      y_last_q <= hmrs_pkg::LAST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hmrs_pkg::CFG_X_LAST: x_last_q <= cfg_data_i;
        hmrs_pkg::CFG_Y_LAST: y_last_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // rectangle latch and row counter
  always_ff @(posedge clk_i) begin
    if (accept) begin
      xl_q   <= x_low_i;
      yl_q   <= y_low_i;
      xh_q   <= xh_c;
      yh_q   <= yh_c;
      add_q  <= box_height_i;
      live_q <= live_c;
      x_q    <= x_low_i;
    end else if (ctrl.sum_ld) begin
      x_q <= xl_q;
    end else if (ctrl.x_inc) begin
      x_q <= x_q + hmrs_pkg::CoordW'(1);
    end
  end

  assign raddr = XW'(x_q);

  // row read, tagged with the pass it belongs to
  always_ff @(posedge clk_i) begin
    if (ctrl.rd_max || ctrl.rd_wr) begin
      rd_q  <= mem[raddr];
      rvb_q <= row_vld_q[raddr];
      wa_q  <= raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdmx_q <= 1'b0;
      rdwr_q <= 1'b0;
      pipe_q <= '0;
    end else begin
      rdmx_q <= ctrl.rd_max;
      rdwr_q <= ctrl.rd_wr;
      pipe_q <= LV'({pipe_q, rdmx_q});
    end
  end

  // lane masks: cells in the y range, zero for rows never written
  for (genvar j = 0; j < NP; j++) begin : g_leaf
    if (j < GRID_Y) begin : g_lane
      logic in_rng;
      assign in_rng = (CW'(j) >= CW'(yl_q)) && (CW'(j) <= CW'(yh_q));
      assign leaf[j] = (in_rng && rvb_q) ? rd_q[j*HB +: HB] : '0;
      assign wdata[j*HB +: HB] = in_rng ? sum_q : (rvb_q ? rd_q[j*HB +: HB] : '0);
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  // registered max tree, heap order, root at node 0
  for (genvar i = 0; i < NP - 1; i++) begin : g_node
    localparam int L = 2 * i + 1;
    localparam int R = 2 * i + 2;
    if (L >= NP - 1) begin : g_bottom
      always_ff @(posedge clk_i) begin
        tree_q[i] <= (leaf[L-NP+1] > leaf[R-NP+1]) ? leaf[L-NP+1] : leaf[R-NP+1];
      end
    end else begin : g_inner
      always_ff @(posedge clk_i) begin
        tree_q[i] <= (tree_q[L] > tree_q[R]) ? tree_q[L] : tree_q[R];
      end
    end
  end

  // running maximum over rows
  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= '0;
    end else if (pipe_q[LV-1] && (tree_q[0] > acc_q)) begin
      acc_q <= tree_q[0];
    end
  end

  // saturating add
  assign sum_w = SW'(acc_q) + SW'(add_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.sum_ld) begin
      sum_q <= (sum_w > HMAX) ? HB'(HMAX) : HB'(sum_w);
    end
  end

  // row write-back, in the cycle after its read
  always_ff @(posedge clk_i) begin
    if (rdwr_q) begin
      mem[wa_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (rdwr_q) begin
      row_vld_q[wa_q] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_ld) begin
      top_q <= hmrs_pkg::TopW'(sum_q);
    end
  end

  assign out_valid_o = out_v_q;
  assign new_top_o   = top_q;

endmodule

// ----- bench/hmrs_checker.sv -----
// hmrs_checker: watches the config port and both word channels of the height map core,
// keeps its own height grid and limits, and compares every new_top word in order.
// Depends on hmrs_pkg for widths and config register indexes.
`timescale 1ns / 100ps

module hmrs_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hmrs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hmrs_pkg::CoordW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [hmrs_pkg::CoordW-1:0]  x_low_i,
  input  logic [hmrs_pkg::CoordW-1:0]  y_low_i,
  input  logic [hmrs_pkg::CoordW-1:0]  x_high_i,
  input  logic [hmrs_pkg::CoordW-1:0]  y_high_i,
  input  logic [hmrs_pkg::BoxW-1:0]    box_height_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [hmrs_pkg::TopW-1:0]    new_top_i,
  output int                           fail_cnt_o,
  output int                           open_cnt_o
);

  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int CELLS = GRID_X * GRID_Y;
  localparam int unsigned HEIGHT_MAX = (1 << hmrs_pkg::TopW) - 1;

  // model grid, cell (x, y) at x * GRID_Y + y
  logic [hmrs_pkg::TopW-1:0] cell_h [CELLS];
  logic [hmrs_pkg::CoordW-1:0] x_last;
  logic [hmrs_pkg::CoordW-1:0] y_last;
  logic [hmrs_pkg::TopW-1:0] top_q [$];
  int mism;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mism++;
  endtask

  // Max over the clipped rectangle plus box, saturated, then written back
  function automatic logic [hmrs_pkg::TopW-1:0] stack_box(
      input logic [hmrs_pkg::CoordW-1:0] xl,
      input logic [hmrs_pkg::CoordW-1:0] yl,
      input logic [hmrs_pkg::CoordW-1:0] xh,
      input logic [hmrs_pkg::CoordW-1:0] yh,
      input logic [hmrs_pkg::BoxW-1:0] box);
    int xe, ye, x, y;
    int unsigned peak, total;
    bit hit;
    xe = int'((xh > x_last) ? x_last : xh);
    ye = int'((yh > y_last) ? y_last : yh);
    if (xe > GRID_X - 1) xe = GRID_X - 1;
    if (ye > GRID_Y - 1) ye = GRID_Y - 1;
    hit = (int'(xl) <= xe) && (int'(yl) <= ye);
    peak = 0;
    if (hit) begin
      for (x = int'(xl); x <= xe; x++)
        for (y = int'(yl); y <= ye; y++)
          if (32'(cell_h[x * GRID_Y + y]) > peak) peak = 32'(cell_h[x * GRID_Y + y]);
    end
    total = peak + 32'(box);
    if (total > HEIGHT_MAX) total = HEIGHT_MAX;
    if (hit) begin
      for (x = int'(xl); x <= xe; x++)
        for (y = int'(yl); y <= ye; y++)
          cell_h[x * GRID_Y + y] = total[hmrs_pkg::TopW-1:0];
    end
    return total[hmrs_pkg::TopW-1:0];
  endfunction

  // Outputs first (older words), then the newly accepted word, then config
  always @(posedge clk_i or negedge rst_ni) begin
    logic [hmrs_pkg::TopW-1:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) cell_h[i] = '0;
      x_last = hmrs_pkg::LAST_RST;
      y_last = hmrs_pkg::LAST_RST;
      top_q.delete();
      mism = 0;
      fail_cnt_o <= 0;
      open_cnt_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (top_q.size() == 0) begin
          report_mismatch($sformatf("new_top %0h with no word pending", new_top_i));
        end else begin
          want = top_q.pop_front();
          if (new_top_i !== want)
            report_mismatch($sformatf("new_top %0h, predicted %0h", new_top_i, want));
        end
      end
      if (in_valid_i && in_ready_i)
        top_q.push_back(stack_box(x_low_i, y_low_i, x_high_i, y_high_i, box_height_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hmrs_pkg::CFG_X_LAST: x_last = cfg_data_i;
          hmrs_pkg::CFG_Y_LAST: y_last = cfg_data_i;
          default: ;
        endcase
      end
      fail_cnt_o <= mism;
      open_cnt_o <= top_q.size();
    end
  end

endmodule

// ----- bench/tb_height_map_rect_stack_core.sv -----
// tb_height_map_rect_stack_core: stimulus and verdict for height_map_rect_stack_core.
// Directed rectangles, then random phases under several x/y limits; hmrs_checker compares.
// Depends on hmrs_pkg, height_map_rect_stack_core and hmrs_checker.
`timescale 1ns / 100ps

module tb_height_map_rect_stack_core;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 150;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [hmrs_pkg::CfgIdxW-1:0] cfg_idx_i = hmrs_pkg::CFG_X_LAST;
  logic [hmrs_pkg::CoordW-1:0]  cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [hmrs_pkg::CoordW-1:0]  x_low_i = '0;
  logic [hmrs_pkg::CoordW-1:0]  y_low_i = '0;
  logic [hmrs_pkg::CoordW-1:0]  x_high_i = '0;
  logic [hmrs_pkg::CoordW-1:0]  y_high_i = '0;
  logic [hmrs_pkg::BoxW-1:0]    box_height_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [hmrs_pkg::TopW-1:0]    new_top_o;

  int fail_cnt;
  int open_cnt;
  int cycle_cnt = 0;
  bit calm = 1'b0;                 // no idling on either side while set
  logic [hmrs_pkg::CoordW-1:0] cur_x = hmrs_pkg::LAST_RST;
  logic [hmrs_pkg::CoordW-1:0] cur_y = hmrs_pkg::LAST_RST;

  always #5 clk_i = ~clk_i;

  height_map_rect_stack_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .x_low_i      (x_low_i),
    .y_low_i      (y_low_i),
    .x_high_i     (x_high_i),
    .y_high_i     (y_high_i),
    .box_height_i (box_height_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .new_top_o    (new_top_o)
  );

  hmrs_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .x_low_i      (x_low_i),
    .y_low_i      (y_low_i),
    .x_high_i     (x_high_i),
    .y_high_i     (y_high_i),
    .box_height_i (box_height_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .new_top_i    (new_top_o),
    .fail_cnt_o   (fail_cnt),
    .open_cnt_o   (open_cnt)
  );

  // Result side: stall at random, except during the calm stretch
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 38);
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one word; returns at the edge that accepts it
  task automatic send_word(input logic [hmrs_pkg::CoordW-1:0] xl,
                           input logic [hmrs_pkg::CoordW-1:0] yl,
                           input logic [hmrs_pkg::CoordW-1:0] xh,
                           input logic [hmrs_pkg::CoordW-1:0] yh,
                           input logic [hmrs_pkg::BoxW-1:0] bh);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    x_low_i      <= xl;
    y_low_i      <= yl;
    x_high_i     <= xh;
    y_high_i     <= yh;
    box_height_i <= bh;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Upper corner of a span starting at lo, mostly narrow
  function automatic logic [hmrs_pkg::CoordW-1:0] span_end(
      input logic [hmrs_pkg::CoordW-1:0] lo);
    int w, hi;
    w = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 63)) :
                                      int'($urandom_range(0, 12));
    hi = int'(lo) + w;
    return (hi > 63) ? 6'd63 : hi[hmrs_pkg::CoordW-1:0];
  endfunction

  // Mostly rectangles anchored inside the used grid; the rest anything
  task automatic send_random(input bit full_box);
    logic [hmrs_pkg::CoordW-1:0] xl, yl, xh, yh;
    logic [hmrs_pkg::BoxW-1:0] bh;
    if ($urandom_range(0, 99) < 80) begin
      xl = hmrs_pkg::CoordW'($urandom_range(0, cur_x));
      yl = hmrs_pkg::CoordW'($urandom_range(0, cur_y));
      xh = span_end(xl);
      yh = span_end(yl);
    end else begin
      xl = hmrs_pkg::CoordW'($urandom_range(0, 63));
      yl = hmrs_pkg::CoordW'($urandom_range(0, 63));
      xh = hmrs_pkg::CoordW'($urandom_range(0, 63));
      yh = hmrs_pkg::CoordW'($urandom_range(0, 63));
    end
    // keep stacks low so saturation stays for the closing phase
    if (full_box) bh = hmrs_pkg::BoxW'($urandom_range(0, 65535));
    else if ($urandom_range(0, 19) == 0) bh = hmrs_pkg::BoxW'($urandom_range(0, 1023));
    else bh = hmrs_pkg::BoxW'($urandom_range(0, 31));
    send_word(xl, yl, xh, yh, bh);
  endtask

  // Stop sending and wait until every result word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (open_cnt != 0);
  endtask

  task automatic set_limits(input logic [hmrs_pkg::CoordW-1:0] xv,
                            input logic [hmrs_pkg::CoordW-1:0] yv);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= hmrs_pkg::CFG_X_LAST;
    cfg_data_i <= xv;
    @(posedge clk_i);
    cfg_idx_i  <= hmrs_pkg::CFG_Y_LAST;
    cfg_data_i <= yv;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_x = xv;
    cur_y = yv;
  endtask

  task automatic run_phase(input logic [hmrs_pkg::CoordW-1:0] xv,
                           input logic [hmrs_pkg::CoordW-1:0] yv,
                           input int count);
    drain();
    set_limits(xv, yv);
    repeat (count) send_random(1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: full grid, corners, empty rectangles with wide boxes
    send_word(6'd0, 6'd0, 6'd63, 6'd63, 16'h0000);
    send_word(6'd0, 6'd0, 6'd0, 6'd0, 16'h0005);
    send_word(6'd63, 6'd63, 6'd63, 6'd63, 16'h0003);
    send_word(6'd0, 6'd0, 6'd63, 6'd63, 16'h0001);
    send_word(6'd40, 6'd0, 6'd39, 6'd63, 16'hFFFF);
    send_word(6'd0, 6'd63, 6'd63, 6'd0, 16'hAAAA);
    send_word(6'd63, 6'd0, 6'd0, 6'd0, 16'h5555);
    send_word(6'd5, 6'd9, 6'd5, 6'd30, 16'h0010);
    send_word(6'd0, 6'd9, 6'd63, 6'd9, 16'h0002);
    send_word(6'd3, 6'd3, 6'd7, 6'd7, 16'h0101);

    // smallest limits: only cell (0,0) is live
    drain();
    set_limits(6'd0, 6'd0);
    send_word(6'd0, 6'd0, 6'd63, 6'd63, 16'h0004);
    send_word(6'd1, 6'd0, 6'd63, 6'd63, 16'h00FF);
    send_word(6'd0, 6'd1, 6'd0, 6'd63, 16'h0009);

    // partial limits: clipped and fully clipped rectangles
    drain();
    set_limits(6'd31, 6'd47);
    send_word(6'd20, 6'd40, 6'd63, 6'd63, 16'h0003);
    send_word(6'd32, 6'd0, 6'd63, 6'd63, 16'h1234);
    send_word(6'd0, 6'd48, 6'd10, 6'd63, 16'h0007);

    // widen again: cells outside before count once more
    drain();
    set_limits(6'd63, 6'd63);
    send_word(6'd0, 6'd0, 6'd63, 6'd63, 16'h0000);
    send_word(6'd62, 6'd62, 6'd63, 6'd63, 16'h0001);

    // random phases under various limits
    run_phase(6'd63, 6'd63, 60);
    calm = 1'b1;
    repeat (120) send_random(1'b0);
    calm = 1'b0;
    run_phase(hmrs_pkg::CoordW'($urandom_range(0, 63)),
              hmrs_pkg::CoordW'($urandom_range(0, 63)), 150);
    run_phase(6'd0, 6'd63, 100);
    run_phase(6'd63, 6'd0, 100);
    run_phase(hmrs_pkg::CoordW'($urandom_range(0, 63)),
              hmrs_pkg::CoordW'($urandom_range(0, 63)), 150);
    run_phase(6'd63, 6'd63, 150);

    // closing phase: drive the grid into saturation, then full-range boxes
    drain();
    set_limits(6'd63, 6'd63);
    send_word(6'd0, 6'd0, 6'd63, 6'd63, 16'hFFFF);
    send_word(6'd0, 6'd0, 6'd0, 6'd0, 16'h0001);
    repeat (50) send_random(1'b1);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
